@@ rtl/chd_pkg.sv @@
// ----------------------------------------------------------------------------
// chd_pkg
// Shared codes, character constants and the result type of the chunked body
// decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int unsigned SizeBitsDefault = 32;

  // command codes
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_CLOSE   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // decode status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_VT   = 8'h0B;
  localparam logic [7:0] CHAR_FF   = 8'h0C;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic [1:0] decode_status;
  } chd_result_t;

endpackage

@@ rtl/chd_core.sv @@
// ----------------------------------------------------------------------------
// chd_core
// Decoder state and its combinational update for one transfer: size line
// parsing, data countdown, chunk end check, trailer lines, close and restart.
// ----------------------------------------------------------------------------
module chd_core #(
  parameter int unsigned SIZE_BITS = chd_pkg::SizeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          command_i,
  input  logic [7:0]          data_byte_i,
  output logic                res_valid_o,
  output chd_pkg::chd_result_t res_o
);
  import chd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_CR,
    PH_LF,
    PH_TRAILER,
    PH_DONE
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [SIZE_BITS-1:0] size_accum_q, size_accum_d;
  logic [SIZE_BITS-1:0] bytes_left_q, bytes_left_d;
  logic                 digit_seen_q, digit_seen_d;
  logic                 hex_stopped_q, hex_stopped_d;
  logic                 in_ext_q, in_ext_d;
  logic                 nonspace_q, nonspace_d;
  logic                 line_nonempty_q, line_nonempty_d;

  logic                 hex_ok;
  logic [3:0]           hex_digit;
  logic                 is_blank;
  logic [SIZE_BITS-1:0] bytes_dec;

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (data_byte_i inside {[8'h30:8'h39]}) begin
      hex_digit = 4'(data_byte_i - 8'h30);
    end else if (data_byte_i inside {[8'h61:8'h66]}) begin
      hex_digit = 4'(data_byte_i - 8'h57);
    end else if (data_byte_i inside {[8'h41:8'h46]}) begin
      hex_digit = 4'(data_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_blank  = (data_byte_i inside {CHAR_SP, CHAR_TAB, CHAR_VT, CHAR_FF});
  assign bytes_dec = bytes_left_q - SIZE_BITS'(1);

  always_comb begin
    phase_d         = phase_q;
    size_accum_d    = size_accum_q;
    bytes_left_d    = bytes_left_q;
    digit_seen_d    = digit_seen_q;
    hex_stopped_d   = hex_stopped_q;
    in_ext_d        = in_ext_q;
    nonspace_d      = nonspace_q;
    line_nonempty_d = line_nonempty_q;
    res_valid_o     = 1'b0;
    res_o           = '0;

    if (step_i) begin
      if (command_i == CMD_RESTART) begin
        phase_d         = PH_SIZE;
        size_accum_d    = '0;
        bytes_left_d    = '0;
        digit_seen_d    = 1'b0;
        hex_stopped_d   = 1'b0;
        in_ext_d        = 1'b0;
        nonspace_d      = 1'b0;
        line_nonempty_d = 1'b0;
      end else if (phase_q != PH_DONE && command_i == CMD_CLOSE) begin
        phase_d             = PH_DONE;
        res_valid_o         = 1'b1;
        res_o.decode_status = (phase_q == PH_TRAILER) ? ST_OK : ST_ERR;
      end else if (phase_q != PH_DONE && command_i == CMD_BYTE) begin
        case (phase_q)
          PH_SIZE: begin
            if (data_byte_i == CHAR_CR) begin
              // carriage returns are dropped
            end else if (data_byte_i == CHAR_LF) begin
              if (!nonspace_q) begin
                phase_d             = PH_DONE;
                res_valid_o         = 1'b1;
                res_o.decode_status = ST_ERR;
              end else begin
                phase_d         = (size_accum_q == '0) ? PH_TRAILER : PH_DATA;
                bytes_left_d    = size_accum_q;
                size_accum_d    = '0;
                digit_seen_d    = 1'b0;
                hex_stopped_d   = 1'b0;
                in_ext_d        = 1'b0;
                nonspace_d      = 1'b0;
                line_nonempty_d = 1'b0;
              end
            end else if (in_ext_q) begin
              // extension text is ignored
            end else if (data_byte_i == CHAR_SEMI) begin
              in_ext_d = 1'b1;
            end else if (is_blank) begin
              if (digit_seen_q) hex_stopped_d = 1'b1;
            end else begin
              nonspace_d = 1'b1;
              if (!hex_stopped_q) begin
                if (!hex_ok) begin
                  hex_stopped_d = 1'b1;
                end else begin
                  digit_seen_d = 1'b1;
                  // saturate once any of the top four bits would shift out
                  if (size_accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
                    size_accum_d = '1;
                  end else begin
                    size_accum_d = {size_accum_q[SIZE_BITS-5:0], hex_digit};
                  end
                end
              end
            end
          end
          PH_DATA: begin
            bytes_left_d     = bytes_dec;
            if (bytes_dec == '0) phase_d = PH_CR;
            res_valid_o      = 1'b1;
            res_o.body_byte  = data_byte_i;
            res_o.body_valid = 1'b1;
          end
          PH_CR: begin
            if (data_byte_i != CHAR_CR) begin
              phase_d             = PH_DONE;
              res_valid_o         = 1'b1;
              res_o.decode_status = ST_ERR;
            end else begin
              phase_d = PH_LF;
            end
          end
          PH_LF: begin
            if (data_byte_i != CHAR_LF) begin
              phase_d             = PH_DONE;
              res_valid_o         = 1'b1;
              res_o.decode_status = ST_ERR;
            end else begin
              phase_d         = PH_SIZE;
              size_accum_d    = '0;
              digit_seen_d    = 1'b0;
              hex_stopped_d   = 1'b0;
              in_ext_d        = 1'b0;
              nonspace_d      = 1'b0;
              line_nonempty_d = 1'b0;
            end
          end
          PH_TRAILER: begin
            if (data_byte_i == CHAR_CR) begin
              // dropped
            end else if (data_byte_i == CHAR_LF) begin
              if (!line_nonempty_q) begin
                phase_d             = PH_DONE;
                res_valid_o         = 1'b1;
                res_o.decode_status = ST_OK;
              end else begin
                line_nonempty_d = 1'b0;
              end
            end else begin
              line_nonempty_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_SIZE;
      size_accum_q    <= '0;
      bytes_left_q    <= '0;
      digit_seen_q    <= 1'b0;
      hex_stopped_q   <= 1'b0;
      in_ext_q        <= 1'b0;
      nonspace_q      <= 1'b0;
      line_nonempty_q <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      size_accum_q    <= size_accum_d;
      bytes_left_q    <= bytes_left_d;
      digit_seen_q    <= digit_seen_d;
      hex_stopped_q   <= hex_stopped_d;
      in_ext_q        <= in_ext_d;
      nonspace_q      <= nonspace_d;
      line_nonempty_q <= line_nonempty_d;
    end
  end

  // the data phase is only entered with a nonzero count
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> bytes_left_q != '0)
    else $error("data phase with zero bytes left");

  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.body_valid |=> phase_q == PH_DONE)
    else $error("final status without finished phase");

endmodule

@@ rtl/http_chunked_body_decoder.sv @@
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked body decoder, one received byte per transfer.
// ----------------------------------------------------------------------------
// throughput: one input transfer per cycle, set by the per-transfer state
//   update in chd_core; a one-entry skid stage keeps input open while the
//   output is stalled, until a second result is waiting
// reset: rst_ni clears the decoder to the start of a size line, outputs empty
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = chd_pkg::SizeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] body_byte_o,
  output logic       body_valid_o,
  output logic [1:0] decode_status_o
);
  import chd_pkg::*;

  logic        in_xfer;
  logic        res_valid;
  chd_result_t res;
  logic        out_valid_q;
  logic        skid_valid_q;
  chd_result_t out_q;
  chd_result_t skid_q;

  assign in_ready_o = !skid_valid_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  chd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_xfer),
    .command_i  (command_i),
    .data_byte_i(data_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= res_valid;
        end
      end else if (!out_valid_q) begin
        out_valid_q <= res_valid;
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (!out_valid_q) begin
      out_q <= res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign body_byte_o     = out_q.body_byte;
  assign body_valid_o    = out_q.body_valid;
  assign decode_status_o = out_q.decode_status;

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output is empty");

  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && body_valid_o |-> decode_status_o == ST_BUSY)
    else $error("data result with final status");

  a_final_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !body_valid_o |-> decode_status_o == ST_OK || decode_status_o == ST_ERR)
    else $error("status result without final status");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q && out_valid_q)
    else $error("stalled results lost");

endmodule
